[src/codon_translate_histogram_assert.svh]
// Assertion macros shared by the checker of the codon translation histogram.
`ifndef CODON_TRANSLATE_HISTOGRAM_ASSERT_SVH
`define CODON_TRANSLATE_HISTOGRAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cth_pkg.sv]
// Types, constants and lookup functions of the codon translation histogram.
package cth_pkg;

  localparam int NUM_AMINO   = 20;
  localparam int AMINO_W     = 5;
  localparam int OUT_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [AMINO_W-1:0] amino_t;
  typedef logic [OUT_W-1:0]   out_word_t;

  // Command codes of the input channel.
  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Nucleotide letters in ASCII.
  localparam logic [7:0] LETTER_T = 8'h54;
  localparam logic [7:0] LETTER_C = 8'h43;
  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_G = 8'h47;

  // Column codes of the translation table.
  localparam logic [1:0] COL_T = 2'd0;
  localparam logic [1:0] COL_C = 2'd1;
  localparam logic [1:0] COL_A = 2'd2;
  localparam logic [1:0] COL_G = 2'd3;

  // Amino acid indices in alphabetical one-letter order.
  localparam amino_t AA_A = 5'd0;
  localparam amino_t AA_C = 5'd1;
  localparam amino_t AA_D = 5'd2;
  localparam amino_t AA_E = 5'd3;
  localparam amino_t AA_F = 5'd4;
  localparam amino_t AA_G = 5'd5;
  localparam amino_t AA_H = 5'd6;
  localparam amino_t AA_I = 5'd7;
  localparam amino_t AA_K = 5'd8;
  localparam amino_t AA_L = 5'd9;
  localparam amino_t AA_M = 5'd10;
  localparam amino_t AA_N = 5'd11;
  localparam amino_t AA_P = 5'd12;
  localparam amino_t AA_Q = 5'd13;
  localparam amino_t AA_R = 5'd14;
  localparam amino_t AA_S = 5'd15;
  localparam amino_t AA_T = 5'd16;
  localparam amino_t AA_V = 5'd17;
  localparam amino_t AA_W = 5'd18;
  localparam amino_t AA_Y = 5'd19;

  // Codon scanner states: start search, then first, second and third letter of a codon.
  typedef enum logic [4:0] {
    SC_IDLE, SC_GOT_A, SC_GOT_AT, SC_FRAME,
    SC_T, SC_TT, SC_TC, SC_TA, SC_TG,
    SC_C, SC_CT, SC_CC, SC_CA, SC_CG,
    SC_A, SC_AT, SC_AC, SC_AA, SC_AG,
    SC_G, SC_GT, SC_GC, SC_GA, SC_GG
  } scan_t;

  // Work handed from the front to the counter back end.
  typedef enum logic [1:0] {OP_NOP, OP_COUNT, OP_READ, OP_CLEAR} op_t;

  typedef struct packed {
    op_t    op;
    amino_t index;
    logic   in_frame;
  } task_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } col_t;

  // Maps a letter to its table column; other bytes give no hit.
  function automatic col_t letter_col(input logic [7:0] letter);
    col_t c;
    c = '{hit: 1'b1, col: COL_T};
    case (letter)
      LETTER_T: c.col = COL_T;
      LETTER_C: c.col = COL_C;
      LETTER_A: c.col = COL_A;
      LETTER_G: c.col = COL_G;
      default:  c.hit = 1'b0;
    endcase
    return c;
  endfunction

endpackage

[src/cth_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
interface cth_in_if;
  import cth_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] letter;
  amino_t     amino_select;

  modport source (output valid, command, letter, amino_select, input ready);
  modport sink   (input valid, command, letter, amino_select, output ready);
endinterface

interface cth_out_if;
  import cth_pkg::*;

  logic      valid;
  logic      ready;
  logic      produced;
  amino_t    amino_index;
  out_word_t amino_count;
  out_word_t total_count;
  logic      in_frame;

  modport source (output valid, produced, amino_index, amino_count, total_count, in_frame,
                  input ready);
  modport sink   (input valid, produced, amino_index, amino_count, total_count, in_frame,
                  output ready);
endinterface

[src/cth_front.sv]
// Front end: accepts transactions, runs the codon scanner and classifies the work.
module cth_front (
  input  logic            clk,
  input  logic            rst_n,
  cth_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output cth_pkg::task_t  q_task
);
  import cth_pkg::*;

  scan_t  scan_r, scan_nxt, trans;
  col_t   col;
  logic   accept;
  logic   emit_valid;
  amino_t emit_amino;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;
  assign col         = letter_col(in_ch.letter);

  // Next state of the scanner for the current letter.
  always_comb begin
    trans = SC_IDLE;
    case (scan_r)
      SC_GOT_A: begin
        if (col.col == COL_T) trans = SC_GOT_AT;
        else if (col.col == COL_A) trans = SC_GOT_A;
      end
      SC_GOT_AT: begin
        if (col.col == COL_A) trans = SC_GOT_A;
        else if (col.col == COL_G) trans = SC_FRAME;
      end
      SC_FRAME: begin
        case (col.col)
          COL_T:   trans = SC_T;
          COL_C:   trans = SC_C;
          COL_A:   trans = SC_A;
          default: trans = SC_G;
        endcase
      end
      SC_T: begin
        case (col.col)
          COL_T:   trans = SC_TT;
          COL_C:   trans = SC_TC;
          COL_A:   trans = SC_TA;
          default: trans = SC_TG;
        endcase
      end
      SC_C: begin
        case (col.col)
          COL_T:   trans = SC_CT;
          COL_C:   trans = SC_CC;
          COL_A:   trans = SC_CA;
          default: trans = SC_CG;
        endcase
      end
      SC_A: begin
        case (col.col)
          COL_T:   trans = SC_AT;
          COL_C:   trans = SC_AC;
          COL_A:   trans = SC_AA;
          default: trans = SC_AG;
        endcase
      end
      SC_G: begin
        case (col.col)
          COL_T:   trans = SC_GT;
          COL_C:   trans = SC_GC;
          COL_A:   trans = SC_GA;
          default: trans = SC_GG;
        endcase
      end
      // Stop codons TAA, TAG and TGA return to the start search.
      SC_TA:   trans = col.col[1] ? SC_IDLE : SC_FRAME;
      SC_TG:   trans = (col.col == COL_A) ? SC_IDLE : SC_FRAME;
      SC_TT, SC_TC, SC_CT, SC_CC, SC_CA, SC_CG, SC_AT, SC_AC, SC_AA, SC_AG,
      SC_GT, SC_GC, SC_GA, SC_GG: trans = SC_FRAME;
      default: trans = (col.col == COL_A) ? SC_GOT_A : SC_IDLE;
    endcase
  end

  // Scanner state update: letters step it, a clear restarts the search.
  always_comb begin
    scan_nxt = scan_r;
    if (accept) begin
      if (in_ch.command == CMD_FEED && col.hit) scan_nxt = trans;
      else if (in_ch.command == CMD_CLEAR) scan_nxt = SC_IDLE;
    end
  end

  // Amino acid completed by the current letter, if any.
  always_comb begin
    emit_valid = 1'b1;
    emit_amino = AA_A;
    case (scan_r)
      SC_GOT_AT: begin
        emit_amino = AA_M;
        emit_valid = (col.col == COL_G);
      end
      SC_TT: emit_amino = col.col[1] ? AA_L : AA_F;
      SC_TC: emit_amino = AA_S;
      SC_TA: begin
        emit_amino = AA_Y;
        emit_valid = !col.col[1];
      end
      SC_TG: begin
        emit_amino = (col.col == COL_G) ? AA_W : AA_C;
        emit_valid = (col.col != COL_A);
      end
      SC_CT: emit_amino = AA_L;
      SC_CC: emit_amino = AA_P;
      SC_CA: emit_amino = col.col[1] ? AA_Q : AA_H;
      SC_CG: emit_amino = AA_R;
      SC_AT: emit_amino = (col.col == COL_G) ? AA_M : AA_I;
      SC_AC: emit_amino = AA_T;
      SC_AA: emit_amino = col.col[1] ? AA_K : AA_N;
      SC_AG: emit_amino = col.col[1] ? AA_R : AA_S;
      SC_GT: emit_amino = AA_V;
      SC_GC: emit_amino = AA_A;
      SC_GA: emit_amino = col.col[1] ? AA_E : AA_D;
      SC_GG: emit_amino = AA_G;
      default: emit_valid = 1'b0;
    endcase
  end

  // Classify the transaction into work for the back end.
  always_comb begin
    q_task.op       = OP_NOP;
    q_task.index    = AA_A;
    q_task.in_frame = (scan_nxt >= SC_FRAME);
    case (in_ch.command)
      CMD_FEED: begin
        if (col.hit && emit_valid) begin
          q_task.op    = OP_COUNT;
          q_task.index = emit_amino;
        end
      end
      CMD_READ: begin
        q_task.op    = OP_READ;
        q_task.index = in_ch.amino_select;
      end
      CMD_CLEAR: q_task.op = OP_CLEAR;
      default:   q_task.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= SC_IDLE;
    end else begin
      scan_r <= scan_nxt;
    end
  end

endmodule

[src/cth_queue.sv]
// Short queue that decouples the front end from the counter back end.
module cth_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cth_pkg::task_t  push_task,
  input  logic            pop,
  output cth_pkg::task_t  pop_task,
  output logic            full,
  output logic            empty
);
  import cth_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  task_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_task = entry_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_task;
  end

endmodule

[src/cth_back.sv]
// Back end: saturating amino acid counters, total counter and the result register.
module cth_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  cth_pkg::task_t  q_task,
  output logic            q_pop,
  cth_out_if.source       out_ch
);
  import cth_pkg::*;

  logic [COUNT_WIDTH-1:0] amino_cnt_r [NUM_AMINO];
  logic [COUNT_WIDTH-1:0] total_r;
  logic [COUNT_WIDTH-1:0] cnt_cur, cnt_inc, tot_inc, cnt_val, tot_val;
  logic                   idx_ok;
  out_word_t              cnt_out, tot_out;

  logic      out_valid_r;
  logic      produced_r, in_frame_r;
  amino_t    index_r;
  out_word_t amino_count_r, total_count_r;

  logic      produced_nxt;
  amino_t    index_nxt;
  out_word_t amino_count_nxt, total_count_nxt;

  // Take the next transaction whenever the result register is free or being drained.
  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  // Read and saturating increment of the addressed counter and the total.
  assign idx_ok  = (q_task.index < AMINO_W'(NUM_AMINO));
  assign cnt_cur = idx_ok ? amino_cnt_r[q_task.index] : '0;
  assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign tot_inc = (total_r == '1) ? total_r : total_r + COUNT_WIDTH'(1);
  assign cnt_val = (q_task.op == OP_COUNT) ? cnt_inc : cnt_cur;
  assign tot_val = (q_task.op == OP_COUNT) ? tot_inc : total_r;

  // Reported values saturate to the 32-bit result fields.
  generate
    if (COUNT_WIDTH > OUT_W) begin : g_wide
      assign cnt_out = (|cnt_val[COUNT_WIDTH-1:OUT_W]) ? '1 : cnt_val[OUT_W-1:0];
      assign tot_out = (|tot_val[COUNT_WIDTH-1:OUT_W]) ? '1 : tot_val[OUT_W-1:0];
    end else begin : g_narrow
      assign cnt_out = OUT_W'(cnt_val);
      assign tot_out = OUT_W'(tot_val);
    end
  endgenerate

  // Result fields for the transaction at the head of the queue.
  always_comb begin
    produced_nxt    = 1'b0;
    index_nxt       = AA_A;
    amino_count_nxt = '0;
    total_count_nxt = tot_out;
    case (q_task.op)
      OP_COUNT: begin
        produced_nxt    = 1'b1;
        index_nxt       = q_task.index;
        amino_count_nxt = cnt_out;
      end
      OP_READ: begin
        index_nxt       = q_task.index;
        amino_count_nxt = cnt_out;
      end
      OP_CLEAR: total_count_nxt = '0;
      default:  total_count_nxt = tot_out;
    endcase
  end

  // Counter update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AMINO; i++) amino_cnt_r[i] <= '0;
      total_r <= '0;
    end else if (q_pop) begin
      case (q_task.op)
        OP_COUNT: begin
          amino_cnt_r[q_task.index] <= cnt_inc;
          total_r                   <= tot_inc;
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_AMINO; i++) amino_cnt_r[i] <= '0;
          total_r <= '0;
        end
        default: total_r <= total_r;
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      produced_r    <= produced_nxt;
      index_r       <= index_nxt;
      amino_count_r <= amino_count_nxt;
      total_count_r <= total_count_nxt;
      in_frame_r    <= q_task.in_frame;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.produced    = produced_r;
  assign out_ch.amino_index = index_r;
  assign out_ch.amino_count = amino_count_r;
  assign out_ch.total_count = total_count_r;
  assign out_ch.in_frame    = in_frame_r;

endmodule

[src/codon_translate_histogram.sv]
// Top level of the codon translation histogram: front end, work queue and counter back end.
// The block takes one transaction per clock cycle and gives exactly one result transaction for
// each. Every input passes the codon scanner in the front end in the cycle it is accepted, so a
// new letter follows the previous one without a gap. The accepting edge writes the work into the
// two-entry queue; the first later edge on which the result register is free or being drained pops
// it, updates the counters and loads the result register. The sustained rate is one
// transaction per cycle, set by the single counter read-modify-write in the back end; a stalled
// result side fills the queue and then holds in_ch.ready low. Reset clears all counters at once;
// no clearing pass is needed.
module codon_translate_histogram #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  cth_in_if.sink    in_ch,
  cth_out_if.source out_ch
);
  import cth_pkg::*;

  task_t push_task, pop_task;
  logic  push, pop, full, empty;

  // Scanner and classification.
  cth_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_task (push_task)
  );

  // Decoupling queue.
  cth_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .pop_task  (pop_task),
    .full      (full),
    .empty     (empty)
  );

  // Counters and result register.
  cth_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_task  (pop_task),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

[src/cth_checker.sv]
// Port-level checker of the codon translation histogram and its bind statement.
`include "codon_translate_histogram_assert.svh"

module cth_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_produced,
  input cth_pkg::amino_t    out_amino_index,
  input cth_pkg::out_word_t out_amino_count,
  input cth_pkg::out_word_t out_total_count,
  input logic               out_in_frame
);
  import cth_pkg::*;

  // A produced amino acid always leaves the scanner in the reading frame.
  `CTH_ASSERT_NOW(a_produced_in_frame, out_valid && out_produced, out_in_frame, "produced amino acid outside the reading frame")

  // A produced amino acid has a valid index and has been counted.
  `CTH_ASSERT_NOW(a_produced_counted, out_valid && out_produced, (out_amino_index < AMINO_W'(NUM_AMINO)) && (out_amino_count != '0) && (out_total_count != '0), "produced amino acid without a valid counted index")

  // No single counter ever exceeds the total.
  `CTH_ASSERT_NOW(a_count_below_total, out_valid, out_amino_count <= out_total_count, "amino acid count above total count")

  // A stalled result transaction holds.
  `CTH_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_amino_index) && $stable(out_amino_count) && $stable(out_total_count), "stalled result transaction changed")

endmodule

bind codon_translate_histogram cth_checker u_cth_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_produced    (out_ch.produced),
  .out_amino_index (out_ch.amino_index),
  .out_amino_count (out_ch.amino_count),
  .out_total_count (out_ch.total_count),
  .out_in_frame    (out_ch.in_frame)
);

[tb/tb_codon_translate_histogram.sv]
// Self-checking testbench of the codon translation histogram: directed and random letter streams.
`timescale 1ns / 100ps

module tb_codon_translate_histogram;
  import cth_pkg::*;

  localparam int COUNT_W = 32;
  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // The fourth command code changes no counter and no scanner state; it still gives a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // A lower-case letter that the scanner must ignore.
  localparam logic [7:0] LETTER_LOWER_T = 8'h74;

  // One expected result transaction.
  typedef struct packed {
    logic      produced;
    amino_t    amino_index;
    out_word_t amino_count;
    out_word_t total_count;
    logic      in_frame;
  } tally_t;

  logic clk;
  logic rst_n;

  cth_in_if  in_ch();
  cth_out_if out_ch();

  codon_translate_histogram #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted state of the scanner and counters.
  scan_t              scan_now;
  logic [COUNT_W-1:0] amino_tally [NUM_AMINO];
  logic [COUNT_W-1:0] grand_tally;

  tally_t tally_q[$];

  int mismatch_count;
  int items_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;

  logic [7:0] bases [4];

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Maps a nucleotide byte to its column; other bytes give no hit.
  function automatic bit base_column(input logic [7:0] ltr, output logic [1:0] col);
    col = COL_T;
    case (ltr)
      LETTER_T: col = COL_T;
      LETTER_C: col = COL_C;
      LETTER_A: col = COL_A;
      LETTER_G: col = COL_G;
      default:  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Standard genetic code for one codon; stop codons raise stop.
  function automatic amino_t codon_amino(input logic [1:0] first, input logic [1:0] second,
                                         input logic [1:0] third, output bit stop);
    bit pyr;
    pyr = (third == COL_T || third == COL_C);
    stop = 1'b0;
    case ({first, second})
      {COL_T, COL_T}: return pyr ? AA_F : AA_L;
      {COL_T, COL_C}: return AA_S;
      {COL_T, COL_A}: begin
        stop = !pyr;
        return AA_Y;
      end
      {COL_T, COL_G}: begin
        stop = (third == COL_A);
        return pyr ? AA_C : AA_W;
      end
      {COL_C, COL_T}: return AA_L;
      {COL_C, COL_C}: return AA_P;
      {COL_C, COL_A}: return pyr ? AA_H : AA_Q;
      {COL_C, COL_G}: return AA_R;
      {COL_A, COL_T}: return (third == COL_G) ? AA_M : AA_I;
      {COL_A, COL_C}: return AA_T;
      {COL_A, COL_A}: return pyr ? AA_N : AA_K;
      {COL_A, COL_G}: return pyr ? AA_S : AA_R;
      {COL_G, COL_T}: return AA_V;
      {COL_G, COL_C}: return AA_A;
      {COL_G, COL_A}: return pyr ? AA_D : AA_E;
      default:        return AA_G;
    endcase
  endfunction

  // Clears the predicted counters and the scanner.
  task automatic clear_tallies();
    scan_now = SC_IDLE;
    for (int i = 0; i < NUM_AMINO; i++) amino_tally[i] = '0;
    grand_tally = '0;
  endtask

  // Applies one accepted transaction to the predicted state and stores the expected result.
  task automatic translate_and_tally(input logic [1:0] cmd, input logic [7:0] ltr,
                                     input amino_t sel);
    tally_t     t;
    logic [1:0] col;
    int         s;
    amino_t     aa;
    bit         stop;
    bit         made;
    t = '0;
    made = 1'b0;
    aa = AA_A;
    stop = 1'b0;
    if (cmd == CMD_FEED) begin
      if (base_column(ltr, col)) begin
        s = int'(scan_now);
        if (s < int'(SC_FRAME)) begin
          // Searching for the start codon.
          if (col == COL_A) scan_now = SC_GOT_A;
          else if (scan_now == SC_GOT_A && col == COL_T) scan_now = SC_GOT_AT;
          else if (scan_now == SC_GOT_AT && col == COL_G) begin
            made = 1'b1;
            aa = AA_M;
            scan_now = SC_FRAME;
          end else scan_now = SC_IDLE;
        end else if (scan_now == SC_FRAME) begin
          scan_now = scan_t'(int'(SC_T) + 5 * int'(col));
        end else if ((s - int'(SC_T)) % 5 == 0) begin
          scan_now = scan_t'(s + 1 + int'(col));
        end else begin
          // Third letter of a codon completes it.
          aa = codon_amino(2'((s - int'(SC_T)) / 5), 2'((s - int'(SC_T)) % 5 - 1), col, stop);
          if (stop) scan_now = SC_IDLE;
          else begin
            made = 1'b1;
            scan_now = SC_FRAME;
          end
        end
        if (made) begin
          if (amino_tally[aa] != '1) amino_tally[aa] = amino_tally[aa] + 1'b1;
          if (grand_tally != '1) grand_tally = grand_tally + 1'b1;
          t.produced = 1'b1;
          t.amino_index = aa;
          t.amino_count = amino_tally[aa];
        end
      end
    end else if (cmd == CMD_READ) begin
      t.amino_index = sel;
      if (sel < NUM_AMINO) t.amino_count = amino_tally[sel];
    end else if (cmd == CMD_CLEAR) begin
      clear_tallies();
    end
    t.total_count = grand_tally;
    t.in_frame = (int'(scan_now) >= int'(SC_FRAME));
    tally_q.push_back(t);
  endtask

  // Offers one transaction, with random idle cycles first, and waits for its acceptance.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ltr, input amino_t sel);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.letter = ltr;
    in_ch.amino_select = sel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    translate_and_tally(cmd, ltr, sel);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] ltr);
    send_item(CMD_FEED, ltr, amino_t'($urandom_range(31)));
  endtask

  // Feeds a nucleotide, now and then preceded by a stray byte.
  task automatic feed_base(input logic [7:0] ltr);
    if ($urandom_range(9) == 0) feed(8'($urandom_range(255)));
    feed(ltr);
  endtask

  task automatic feed_codon(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    feed_base(a);
    feed_base(b);
    feed_base(c);
  endtask

  task automatic read_counter(input amino_t sel);
    send_item(CMD_READ, 8'($urandom_range(255)), sel);
  endtask

  // A reading frame: random lead-in, start codon, random codons and usually a stop codon.
  task automatic send_orf();
    int n;
    n = $urandom_range(3);
    repeat (n) feed_base(bases[$urandom_range(3)]);
    feed_codon(LETTER_A, LETTER_T, LETTER_G);
    n = $urandom_range(8);
    repeat (n) feed_codon(bases[$urandom_range(3)], bases[$urandom_range(3)],
                          bases[$urandom_range(3)]);
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(2))
        0:       feed_codon(LETTER_T, LETTER_A, LETTER_A);
        1:       feed_codon(LETTER_T, LETTER_A, LETTER_G);
        default: feed_codon(LETTER_T, LETTER_G, LETTER_A);
      endcase
    end
  endtask

  // Sender stops offering until every expected result has arrived.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (tally_q.size() != 0) @(negedge clk);
  endtask

  // Field extremes, every command and the named corner cases.
  task automatic test_directed();
    send_item(CMD_CLEAR, 8'hFF, 5'd31);
    feed(8'h00);
    feed(8'hFF);
    feed(LETTER_LOWER_T);
    send_item(CMD_UNUSED, 8'hAA, 5'd21);
    read_counter(5'd31);
    read_counter(5'd20);
    // Start codon, tryptophan, then a stop codon whose tail must not begin a new start.
    feed(LETTER_A);
    feed(LETTER_T);
    feed(LETTER_G);
    feed(LETTER_T);
    feed(LETTER_G);
    feed(LETTER_G);
    feed(LETTER_T);
    feed(LETTER_G);
    feed(LETTER_A);
    feed(LETTER_T);
    feed(LETTER_G);
    read_counter(AA_W);
    read_counter(AA_M);
    // A clear in the middle of a start codon resets the search.
    feed(LETTER_A);
    feed(LETTER_T);
    send_item(CMD_CLEAR, 8'h00, 5'd0);
    feed(LETTER_G);
    read_counter(AA_M);
  endtask

  // Mostly well-formed frames with random content, plus reads, clears and noise.
  task automatic test_random_mix(input int count);
    int target;
    int r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 70) send_orf();
      else if (r < 82) read_counter(amino_t'($urandom_range(31)));
      else if (r < 84) send_item(CMD_CLEAR, 8'($urandom_range(255)),
                                 amino_t'($urandom_range(31)));
      else if (r < 88) send_item(CMD_UNUSED, 8'($urandom_range(255)),
                                 amino_t'($urandom_range(31)));
      else feed(8'($urandom_range(255)));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_receiver_holdoff();
    hold_left = 60;
    repeat (10) send_orf();
  endtask

  // Sender pauses until the block is empty, then every counter is read back.
  task automatic test_sender_pause();
    send_orf();
    wait_drained();
    for (int i = 0; i < NUM_AMINO; i++) read_counter(amino_t'(i));
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Result receiver: random stalls and an optional long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tally_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: index=%0d count=%0d total=%0d",
                                out_ch.amino_index, out_ch.amino_count, out_ch.total_count));
      end else begin
        want = tally_q.pop_front();
        if (out_ch.produced !== want.produced || out_ch.amino_index !== want.amino_index ||
            out_ch.amino_count !== want.amino_count ||
            out_ch.total_count !== want.total_count || out_ch.in_frame !== want.in_frame) begin
          note_mismatch($sformatf(
            "expected produced=%0b index=%0d count=%0d total=%0d frame=%0b, got %0b %0d %0d %0d %0b",
            want.produced, want.amino_index, want.amino_count, want.total_count, want.in_frame,
            out_ch.produced, out_ch.amino_index, out_ch.amino_count, out_ch.total_count,
            out_ch.in_frame));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    bases = '{LETTER_T, LETTER_C, LETTER_A, LETTER_G};
    mismatch_count = 0;
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    clear_tallies();
    in_ch.valid = 1'b0;
    in_ch.command = CMD_FEED;
    in_ch.letter = 8'h00;
    in_ch.amino_select = '0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(420);
    test_receiver_holdoff();

    send_idle_pct = 84;
    test_random_mix(420);
    test_sender_pause();

    send_idle_pct = 0;
    stall_pct = 84;
    test_random_mix(420);

    send_idle_pct = 28;
    stall_pct = 28;
    test_random_mix(420);

    // Let the last results arrive and the block settle.
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && tally_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/cth_pkg.sv
src/cth_if.sv
src/cth_front.sv
src/cth_queue.sv
src/cth_back.sv
src/codon_translate_histogram.sv
src/cth_checker.sv
tb/tb_codon_translate_histogram.sv
